>>> src/pci_bar_decode_and_window_allocator_macros.svh
// assertion macros shared by the bar decoder modules
// each expects signals named clock and reset in the module that uses it
`ifndef PCI_BAR_DECODE_AND_WINDOW_ALLOCATOR_MACROS_SVH
`define PCI_BAR_DECODE_AND_WINDOW_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PBDWA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pbdwa same-cycle check failed");

// next-cycle implication
`define PBDWA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pbdwa next-cycle check failed");

`endif

>>> src/pbdwa_pkg.sv
// shared types, codes and reset constants for the bar decoder and window allocator
// no dependencies
package pbdwa_pkg;

   // depth of the queue between classifier and allocator
   localparam int PBDWA_QUEUE_DEPTH = 2;

   // reset values of the window registers
   localparam logic [15:0] IO_START_RESET  = 16'hC000;
   localparam logic [16:0] IO_LIMIT_RESET  = 17'h10000;
   localparam logic [31:0] MEM_START_RESET = 32'hE000_0000;
   localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

   // register indexes of the csr port
   localparam logic [1:0] CSR_IO_START  = 2'd0;
   localparam logic [1:0] CSR_IO_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_MEM_START = 2'd2;

   // bar index bounds
   localparam logic [2:0] BAR_COUNT_BRIDGE = 3'd2;
   localparam logic [2:0] BAR_COUNT_NORMAL = 3'd6;
   localparam logic [2:0] BAR_LAST_WIDE    = 3'd5;

   typedef struct packed {
      logic [31:0] raw_value;
      logic [31:0] probe_value;
      logic [2:0]  bar_slot;
      logic        is_bridge;
   } req_word_type;

   typedef struct packed {
      logic        is_io;
      logic        is_wide;
      logic        prefetchable;
      logic [31:0] bar_size;
      logic [31:0] bar_base;
      logic        newly_assigned;
      logic [1:0]  status;
   } rsp_word_type;

   // classified bar, handed from front to back
   typedef struct packed {
      logic        is_io;
      logic        is_wide;
      logic        prefetchable;
      logic [31:0] bar_size;
      logic [31:0] bar_base;
      logic        alloc_req;
      logic        bad_index;
   } class_word_type;

   typedef struct packed {
      logic        we;
      logic [1:0]  index;
      logic [31:0] wdata;
   } csr_write_type;

endpackage

>>> src/pci_bar_decode_and_window_allocator.sv
// top level of the pci bar decoder and address window allocator
// depends on pbdwa_pkg, pbdwa_front, pbdwa_queue and pbdwa_back
//
//   channel   ports                            word / data
//   req       req_valid, req_stall, req_word   raw, probe, index, bridge
//   rsp       rsp_valid, rsp_stall, rsp_word   flags, size, base, status
//   csr       csr_we, csr_index, csr_wdata     window start / limit writes
//
// one word per cycle sustained when nothing stalls; a word reaches rsp_valid through the
// front register, queue slot and result register
// the allocator's round-up, add and limit compare are combinational, so pointer
// updates never hold the pipe
// reset is synchronous: empties all stages and reloads the window registers
// a rsp stall fills the result register, then the queue, then stalls req
module pci_bar_decode_and_window_allocator
   import pbdwa_pkg::*;
#(
   parameter int QUEUE_DEPTH = PBDWA_QUEUE_DEPTH
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic           push;
   class_word_type push_word;
   logic           q_full;
   logic           pop;
   logic           head_valid;
   class_word_type head_word;
   csr_write_type  csr;

   // csr port bundle
   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   // classifier
   pbdwa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_full    (q_full),
      .push      (push),
      .push_word (push_word)
   );

   // decoupling queue
   pbdwa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (push_word),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_word  (head_word)
   );

   // allocator and result register
   pbdwa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .head_valid (head_valid),
      .head_word  (head_word),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

>>> src/pbdwa_front.sv
// front stage: accepts a bar word, decodes type, flags, size and base
// depends on pbdwa_pkg
module pbdwa_front
   import pbdwa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_word_type   req_word,
   input  logic           q_full,
   output logic           push,
   output class_word_type push_word
);

   logic           front_valid_ff;
   logic           front_valid_in;
   class_word_type front_word_ff;
   class_word_type front_word_in;
   logic           accept;
   logic           bad_index;
   logic           raw_empty;
   logic [31:0]    masked_probe;
   logic [31:0]    size;
   logic           raw_io;

   // handshake: hold while the queue is full
   assign req_stall      = front_valid_ff & q_full;
   assign accept         = req_valid & ~req_stall;
   assign push           = front_valid_ff & ~q_full;
   assign push_word      = front_word_ff;
   assign front_valid_in = accept | (front_valid_ff & ~push);

   // index check and empty raw value
   assign bad_index = req_word.is_bridge ? (req_word.bar_slot >= BAR_COUNT_BRIDGE)
                                         : (req_word.bar_slot >= BAR_COUNT_NORMAL);
   assign raw_empty = (req_word.raw_value == 32'd0) || (req_word.raw_value == ALL_ONES);
   assign raw_io    = req_word.raw_value[0];

   // size: two's complement of the masked probe, zero for an empty probe or masked probe
   always_comb begin
      masked_probe = req_word.probe_value[0] ? {req_word.probe_value[31:2], 2'b00}
                                             : {req_word.probe_value[31:4], 4'b0000};
      if ((req_word.probe_value == 32'd0) || (req_word.probe_value == ALL_ONES) ||
          (masked_probe == 32'd0)) begin
         size = 32'd0;
      end else begin
         size = ~masked_probe + 32'd1;
      end
   end

   // classified word
   always_comb begin
      front_word_in = '0;
      if (bad_index) begin
         front_word_in.bad_index = 1'b1;
      end else if (!raw_empty) begin
         front_word_in.is_io    = raw_io;
         front_word_in.bar_size = size;
         if (raw_io) begin
            front_word_in.bar_base = {req_word.raw_value[31:2], 2'b00};
         end else begin
            front_word_in.bar_base     = {req_word.raw_value[31:4], 4'b0000};
            front_word_in.prefetchable = req_word.raw_value[3];
            front_word_in.is_wide      = (req_word.raw_value[2:1] == 2'b10) &&
                                         (req_word.bar_slot < BAR_LAST_WIDE);
         end
         front_word_in.alloc_req = (size != 32'd0) && (front_word_in.bar_base == 32'd0);
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_word_ff <= front_word_in;
      end
   end

endmodule

>>> src/pbdwa_queue.sv
// short fifo of classified words between the front and back stages
// depends on pbdwa_pkg and the assertion macro header
`include "pci_bar_decode_and_window_allocator_macros.svh"
module pbdwa_queue
   import pbdwa_pkg::*;
#(
   parameter int DEPTH = PBDWA_QUEUE_DEPTH
)(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  class_word_type push_word,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output class_word_type head_word
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   class_word_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_word  = slot_ff[rd_ptr_ff];

   // pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   `PBDWA_ASSERT_NOW(a_no_push_full, push, !full)
   `PBDWA_ASSERT_NOW(a_no_pop_empty, pop, head_valid)
   `PBDWA_ASSERT_NOW(a_empty_ptrs, (count_ff == '0), (wr_ptr_ff == rd_ptr_ff))
   `PBDWA_ASSERT_NOW(a_count_bound, 1'b1, (count_ff <= FULL_CNT))

endmodule

>>> src/pbdwa_back.sv
// back stage: window pointers, allocation and the result register
// depends on pbdwa_pkg and the assertion macro header
`include "pci_bar_decode_and_window_allocator_macros.svh"
module pbdwa_back
   import pbdwa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  csr_write_type  csr,
   input  logic           head_valid,
   input  class_word_type head_word,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_word_type   rsp_word
);

   logic [31:0]  io_next_ff;
   logic [31:0]  io_next_in;
   logic [31:0]  mem_next_ff;
   logic [31:0]  mem_next_in;
   logic [16:0]  io_limit_ff;
   logic [16:0]  io_limit_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;
   rsp_word_type result;
   logic [31:0]  window_ptr;
   logic [31:0]  step;
   logic [32:0]  bumped;
   logic [32:0]  alloc_start;
   logic [33:0]  alloc_end;
   logic         fits;
   logic         granted;
   logic         fresh_seen;
   logic         bad_seen;
   logic         bad_clean;
   logic         ptr_quiet;

   assign pop       = head_valid & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // round the pointer up to the size and check the window end
   assign window_ptr  = head_word.is_io ? io_next_ff : mem_next_ff;
   assign step        = head_word.bar_size - 32'd1;
   assign bumped      = {1'b0, window_ptr} + {1'b0, step};
   assign alloc_start = bumped & ~{1'b0, step};
   assign alloc_end   = {1'b0, alloc_start} + {2'b00, head_word.bar_size};
   assign fits        = head_word.is_io ? (alloc_end <= {17'd0, io_limit_ff})
                                        : (alloc_end[33:32] == 2'b00);
   assign granted     = head_word.alloc_req & fits;

   // result word
   always_comb begin
      result = '0;
      if (head_word.bad_index) begin
         result.status = STATUS_BAD_INDEX;
      end else begin
         result.is_io        = head_word.is_io;
         result.is_wide      = head_word.is_wide;
         result.prefetchable = head_word.prefetchable;
         result.bar_size     = head_word.bar_size;
         result.bar_base     = head_word.bar_base;
         if (head_word.alloc_req) begin
            if (fits) begin
               result.bar_base       = alloc_start[31:0];
               result.newly_assigned = 1'b1;
            end else begin
               result.bar_base = 32'd0;
               result.status   = STATUS_NO_SPACE;
            end
         end
      end
   end

   // output register
   assign rsp_valid_in = pop | (rsp_valid_ff & rsp_stall);
   assign rsp_word_in  = pop ? result : rsp_word_ff;

   // window pointers: csr writes reload them, grants advance them
   always_comb begin
      io_next_in  = io_next_ff;
      mem_next_in = mem_next_ff;
      io_limit_in = io_limit_ff;
      if (csr.we && (csr.index == CSR_IO_START)) begin
         io_next_in = {16'd0, csr.wdata[15:0]};
      end else if (pop && granted && head_word.is_io) begin
         io_next_in = alloc_end[31:0];
      end
      if (csr.we && (csr.index == CSR_MEM_START)) begin
         mem_next_in = csr.wdata;
      end else if (pop && granted && !head_word.is_io) begin
         mem_next_in = alloc_end[31:0];
      end
      if (csr.we && (csr.index == CSR_IO_LIMIT)) begin
         io_limit_in = csr.wdata[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         io_next_ff   <= {16'd0, IO_START_RESET};
         mem_next_ff  <= MEM_START_RESET;
         io_limit_ff  <= IO_LIMIT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         io_next_ff   <= io_next_in;
         mem_next_ff  <= mem_next_in;
         io_limit_ff  <= io_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   // terms for the checks below
   assign fresh_seen = rsp_valid_ff & rsp_word_ff.newly_assigned;
   assign bad_seen   = rsp_valid_ff & (rsp_word_ff.status == STATUS_BAD_INDEX);
   assign bad_clean  = (rsp_word_ff.bar_size == 32'd0) && (rsp_word_ff.bar_base == 32'd0) &&
                       !rsp_word_ff.newly_assigned;
   assign ptr_quiet  = !pop && !csr.we;

   `PBDWA_ASSERT_NOW(a_fresh_ok, fresh_seen, (rsp_word_ff.status == STATUS_OK))
   `PBDWA_ASSERT_NOW(a_bad_idx_clean, bad_seen, bad_clean)
   `PBDWA_ASSERT_NEXT(a_ptr_hold, ptr_quiet, ($stable(io_next_ff) && $stable(mem_next_ff)))

endmodule

>>> sim/pbdwa_bar_result_checker.sv
// result checker for the pci bar decoder: predicts each rsp word from the req words
// and csr writes it sees, then compares rsp words in order; depends on pbdwa_pkg
module pbdwa_bar_result_checker
   import pbdwa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   output int           mismatch_count,
   output int           pending_words
);

   // decoded bars still owed by the block, oldest first
   rsp_word_type expected_bars[$];
   rsp_word_type want;

   // window state as the block should hold it
   logic [16:0] io_limit;
   logic [31:0] io_cursor;
   logic [31:0] mem_cursor;
   int          mismatch_total = 0;

   // decode one bar and allocate from the matching window
   function automatic rsp_word_type decode_and_allocate(input req_word_type w);
      rsp_word_type r;
      logic [2:0]   count;
      logic [31:0]  masked;
      logic [63:0]  round_mask;
      logic [63:0]  first_addr;
      logic [63:0]  past_end;
      logic         fits;
      r = '0;
      count = w.is_bridge ? BAR_COUNT_BRIDGE : BAR_COUNT_NORMAL;
      if (w.bar_slot >= count) begin
         r.status = STATUS_BAD_INDEX;
         return r;
      end
      // empty raw value reports nothing at all
      if (w.raw_value == 32'h0 || w.raw_value == ALL_ONES)
         return r;
      if (w.raw_value[0]) begin
         r.is_io    = 1'b1;
         r.bar_base = w.raw_value & 32'hFFFF_FFFC;
      end else begin
         r.prefetchable = w.raw_value[3];
         r.is_wide      = (w.raw_value[2:1] == 2'd2) && (w.bar_slot < BAR_LAST_WIDE);
         r.bar_base     = w.raw_value & 32'hFFFF_FFF0;
      end
      // size from the probe readback, flag bits cleared
      if (w.probe_value != 32'h0 && w.probe_value != ALL_ONES) begin
         masked = w.probe_value[0] ? (w.probe_value & 32'hFFFF_FFFC)
                                   : (w.probe_value & 32'hFFFF_FFF0);
         r.bar_size = -masked;
      end
      // unassigned bar: round the cursor up and hand out space
      if (r.bar_size != 32'h0 && r.bar_base == 32'h0) begin
         round_mask = {32'h0, r.bar_size} - 64'h1;
         first_addr = ({32'h0, r.is_io ? io_cursor : mem_cursor} + round_mask) & ~round_mask;
         past_end   = first_addr + {32'h0, r.bar_size};
         fits = r.is_io ? (past_end <= {47'h0, io_limit}) : (past_end[63:32] == 32'h0);
         if (fits) begin
            r.bar_base       = first_addr[31:0];
            r.newly_assigned = 1'b1;
            if (r.is_io)
               io_cursor = past_end[31:0];
            else
               mem_cursor = past_end[31:0];
         end else begin
            r.status = STATUS_NO_SPACE;
         end
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
      if (got_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, got_val);
         mismatch_total++;
      end
   endtask

   // track csr writes, predict on req words, compare on rsp words
   always @(posedge clock) begin
      if (reset) begin
         expected_bars.delete();
         io_limit   = IO_LIMIT_RESET;
         io_cursor  = {16'h0, IO_START_RESET};
         mem_cursor = MEM_START_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IO_START:  io_cursor  = {16'h0, csr_wdata[15:0]};
               CSR_IO_LIMIT:  io_limit   = csr_wdata[16:0];
               CSR_MEM_START: mem_cursor = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_bars.size() == 0) begin
               $display("%0t: unexpected rsp word, expected none, actual %h", $time, rsp_word);
               mismatch_total++;
            end else begin
               want = expected_bars.pop_front();
               check_field("is_io", 32'(want.is_io), 32'(rsp_word.is_io));
               check_field("is_wide", 32'(want.is_wide), 32'(rsp_word.is_wide));
               check_field("prefetchable", 32'(want.prefetchable),
                           32'(rsp_word.prefetchable));
               check_field("bar_size", want.bar_size, rsp_word.bar_size);
               check_field("bar_base", want.bar_base, rsp_word.bar_base);
               check_field("newly_assigned", 32'(want.newly_assigned),
                           32'(rsp_word.newly_assigned));
               check_field("status", 32'(want.status), 32'(rsp_word.status));
            end
         end
         if (req_valid && !req_stall)
            expected_bars.push_back(decode_and_allocate(req_word));
      end
      pending_words  <= expected_bars.size();
      mismatch_count <= mismatch_total;
   end

endmodule

>>> sim/pci_bar_decode_and_window_allocator_test.sv
// testbench top for the pci bar decoder and window allocator: drives bar words,
// csr window settings and rsp stalls; depends on pbdwa_pkg and pbdwa_bar_result_checker
module pci_bar_decode_and_window_allocator_test;
   import pbdwa_pkg::*;

   localparam int IDLE_LIMIT  = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_WORDS = 120;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_we    = 1'b0;
   logic [1:0]   csr_index = CSR_IO_START;
   logic [31:0]  csr_wdata = 32'h0;

   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_asked  = 0;
   int idle_cycles = 0;
   int mismatch_count;
   int pending_words;
   int idle_set[4]  = '{0, 70, 0, 8};
   int stall_set[4] = '{0, 0, 70, 8};

   pci_bar_decode_and_window_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pbdwa_bar_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold-off whenever one is asked for
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // offer one word, with random idle cycles ahead of it
   task automatic send_word(input req_word_type w);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic offer_bar(input logic [31:0] raw, input logic [31:0] probe,
                            input logic [2:0] index, input logic bridge);
      req_word_type w;
      w.raw_value   = raw;
      w.probe_value = probe;
      w.bar_slot    = index;
      w.is_bridge   = bridge;
      send_word(w);
   endtask

   // stop offering and wait for every outstanding rsp word
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // mostly well-formed bars with random sizes and flags, some raw noise
   function automatic req_word_type random_bar_word();
      req_word_type w;
      int           kind;
      int           size_log;
      logic [31:0]  size_mask;
      logic [31:0]  base;
      logic [31:0]  flags;
      kind          = $urandom_range(0, 99);
      w.raw_value   = $urandom;
      w.probe_value = $urandom;
      w.bar_slot    = 3'($urandom_range(0, 7));
      w.is_bridge   = 1'($urandom_range(0, 1));
      if (kind < 12)
         return w;
      w.is_bridge = ($urandom_range(0, 4) == 0);
      w.bar_slot  = w.is_bridge ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 5));
      if ($urandom_range(0, 2) == 0) begin
         size_log = ($urandom_range(0, 19) == 0) ? $urandom_range(2, 17) : $urandom_range(2, 9);
         flags    = 32'h1;
      end else begin
         size_log = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 31)
                                                 : $urandom_range(4, 24);
         flags    = {28'h0, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 1'b0};
      end
      size_mask     = ~((32'h1 << size_log) - 32'h1);
      base          = ($urandom_range(0, 3) == 0) ? ($urandom & size_mask) : 32'h0;
      w.raw_value   = base | flags;
      w.probe_value = size_mask | flags;
      // occasional empty raw, empty probe or irregular size
      case ($urandom_range(0, 19))
         0: w.raw_value = $urandom_range(0, 1) ? ALL_ONES : 32'h0;
         1: w.probe_value = $urandom_range(0, 1) ? ALL_ONES : 32'h0;
         2: w.probe_value = $urandom | flags;
         default: ;
      endcase
      return w;
   endfunction

   // main stimulus
   initial begin
      logic [31:0] io_start;
      logic [31:0] io_limit;
      logic [31:0] mem_start;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words against the reset windows
      offer_bar(32'h0000_0001, 32'hFFFF_FF01, 3'd0, 1'b0); // io allocation
      offer_bar(32'h0000_0000, 32'hFFF0_0000, 3'd1, 1'b0); // empty raw, zero
      offer_bar(ALL_ONES,      32'hFFF0_0000, 3'd2, 1'b0); // empty raw, all ones
      offer_bar(32'h0000_0004, 32'hFFF0_0004, 3'd0, 1'b0); // 64-bit mem allocation
      offer_bar(32'hFEB0_0004, 32'h0000_0000, 3'd1, 1'b0); // upper-half slot, empty probe
      offer_bar(32'h0000_000C, 32'hFFFF_C00C, 3'd4, 1'b0); // prefetch 64-bit
      offer_bar(32'h0000_0004, 32'hFFFF_0004, 3'd5, 1'b0); // 64-bit type at last index
      offer_bar(32'h0000_0006, 32'hFFFF_F006, 3'd3, 1'b0); // reserved mem type
      offer_bar(32'h0000_0001, ALL_ONES,      3'd0, 1'b0); // probe all ones
      offer_bar(32'h0000_0001, 32'h0000_0001, 3'd2, 1'b0); // io masked probe zero
      offer_bar(32'h0000_0008, 32'h0000_000E, 3'd3, 1'b0); // mem masked probe zero
      offer_bar(32'h0000_0001, 32'hFFFF_FF31, 3'd1, 1'b0); // irregular io size
      offer_bar(32'h0000_0008, 32'hFFFF_F0A8, 3'd2, 1'b0); // irregular mem size
      offer_bar(32'hFEB0_0000, 32'hFFF0_0000, 3'd3, 1'b0); // mem base already set
      offer_bar(32'h0000_E001, 32'hFFFF_FF01, 3'd4, 1'b0); // io base already set
      offer_bar(32'h0000_0001, 32'hFFFF_0001, 3'd0, 1'b0); // io beyond limit
      offer_bar(32'h0000_0008, 32'h8000_0008, 3'd1, 1'b0); // mem rounds past the top
      offer_bar(32'h0000_0008, 32'h0000_0010, 3'd2, 1'b0); // largest mem size
      offer_bar(32'h0000_0001, 32'h0000_0005, 3'd3, 1'b0); // largest io size
      offer_bar(32'h0000_0004, 32'hFFF0_0004, 3'd6, 1'b0); // bad index
      offer_bar(32'h0000_0004, 32'hFFF0_0004, 3'd7, 1'b1); // bad index on bridge
      offer_bar(32'h0000_0001, 32'hFFFF_FFF1, 3'd2, 1'b1); // bridge past its bars
      offer_bar(32'h0000_0001, 32'hFFFF_FFF1, 3'd1, 1'b1); // bridge io allocation
      offer_bar(32'hFFFF_FFFE, 32'hFFFF_FFFE, 3'd0, 1'b1); // near all-ones mem base
      offer_bar(32'h0000_0008, 32'hFFFF_FFF8, 3'd5, 1'b0); // small mem allocation

      // random phases, each over several window settings
      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_set[p];
         stall_pct = stall_set[p];
         for (int s = 0; s < 4; s++) begin
            drain_results();
            case ((p * 4 + s) % 5)
               0: begin
                  io_start = {16'h0, IO_START_RESET};
                  io_limit = {15'h0, IO_LIMIT_RESET};
                  mem_start = MEM_START_RESET;
               end
               1: begin
                  io_start = 32'h0;
                  io_limit = 32'h0001_0000;
                  mem_start = 32'h0;
               end
               2: begin
                  io_start = 32'h0000_FFFF;
                  io_limit = 32'h0001_0000;
                  mem_start = ALL_ONES;
               end
               3: begin
                  io_start = 32'h0000_1000;
                  io_limit = 32'h1;
                  mem_start = 32'h8000_0000;
               end
               default: begin
                  io_start = $urandom_range(0, 65535);
                  io_limit = $urandom_range(1, 65536);
                  mem_start = $urandom;
               end
            endcase
            write_csr(CSR_IO_LIMIT, io_limit);
            write_csr(CSR_IO_START, io_start);
            write_csr(CSR_MEM_START, mem_start);
            // long rsp hold-off while words keep coming
            if (s == 1 && (p == 0 || p == 3))
               hold_asked++;
            for (int n = 0; n < PHASE_WORDS; n++) begin
               send_word(random_bar_word());
               if (p == 1 && s == 2 && n == PHASE_WORDS / 2)
                  drain_results();
            end
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
